/* src/pe_base_relocation_walker_assert.svh */
// Assertion macros for the PE-COFF base relocation walker.
// Expects a clock named clk and an active-high synchronous reset named rst.
`ifndef PE_BASE_RELOCATION_WALKER_ASSERT_SVH
`define PE_BASE_RELOCATION_WALKER_ASSERT_SVH

// Same-cycle implication.
`define PBRW_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PBRW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pbrw_pkg.sv */
// Shared types and constants for the PE-COFF base relocation walker.
// No dependencies.
package pbrw_pkg;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ENTRY_W  = 31;

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_LOAD_BASE      = 2'd0;
  localparam logic [1:0] REG_PREFERRED_BASE = 2'd1;
  localparam logic [1:0] REG_TABLE_BYTES    = 2'd2;
  localparam logic [1:0] REG_RISCV_TYPES    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PATCH      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED  = 3'd4;

  // Patch operations
  localparam logic [OP_W-1:0] OP_ADD16_HIGH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD16_LOW  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD32      = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD64      = 3'd3;
  localparam logic [OP_W-1:0] OP_HI20_MERGE = 3'd4;

  // Relocation entry types
  localparam logic [3:0] RT_ABSOLUTE     = 4'd0;
  localparam logic [3:0] RT_HIGH         = 4'd1;
  localparam logic [3:0] RT_LOW          = 4'd2;
  localparam logic [3:0] RT_HIGHLOW      = 4'd3;
  localparam logic [3:0] RT_RISCV_HI20   = 4'd5;
  localparam logic [3:0] RT_RISCV_LOW12I = 4'd7;
  localparam logic [3:0] RT_RISCV_LOW12S = 4'd8;
  localparam logic [3:0] RT_DIR64        = 4'd10;

  localparam logic [11:0] PAGE_MASK = 12'hfff;
  localparam logic [31:0] MIN_BLOCK_BYTES = 32'd8;

  typedef struct packed {
    logic                last;
    logic [DATA_W-1:0]   addend;
    logic [OP_W-1:0]     patch_op;
    logic [ADDR_W-1:0]   patch_offset;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

/* src/pe_base_relocation_walker.sv */
// PE-COFF base relocation walker: top level, header/entry decode and result queue.
// Depends on pbrw_pkg and pe_base_relocation_walker_assert.svh.
//
// Usage:
//   Slave stream (s_*) carries the relocation table, one halfword per item:
//   s_tdata[15:0] = table_half, s_tuser[0] = first (restarts the walk).
//   Master stream (m_*) carries patch commands and status results; m_tlast
//   marks the final result caused by one input item.
//   The APB port holds load_base (0x00), preferred_base (0x08), table_bytes
//   (0x10) and riscv_types (0x18); write them only while the walker is idle.
//   Each halfword is decoded in the cycle it is accepted and its 0..2 results
//   are written into a 4-entry result queue; the queue head drives m_*.
//   A result reaches m_* once its halfword is taken and the results ahead of it are out.
//   Throughput: one halfword per cycle while results drain as fast as they
//   are made; a halfword whose patch entry ends the table's last block gives
//   two results, the patch and the done result.
//   s_tready is high while at most two results wait; a stalled receiver lets
//   the walker fill the queue to three or four results, then s_tready drops.
//   Reset clears all registers, the walk state and the queue.
`default_nettype none

module pe_base_relocation_walker
  import pbrw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // APB configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic      [63:0]  prdata,
  output logic              pready,
  // table halfword stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // [15:0] table_half
  input  wire logic [0:0]   s_tuser,   // [0] first
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // [2:0] status, [34:3] patch_offset,
                                       // [37:35] patch_op, [101:38] addend, zero pad
  output logic              m_tlast
);

  typedef enum logic [2:0] {
    PH_BASE_LO,
    PH_BASE_HI,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_ENTRY
  } phase_t;

  localparam int unsigned QDEPTH = 4;

  // configuration registers
  logic [DATA_W-1:0] load_base;
  logic [DATA_W-1:0] preferred_base;
  logic [31:0]       table_bytes;
  logic              riscv_types;

  // walk state
  phase_t             phase, phase_next;
  logic [15:0]        low_half, low_half_next;
  logic [ADDR_W-1:0]  page_base, page_base_next;
  logic [ENTRY_W-1:0] entries_left, entries_left_next;
  logic [31:0]        bytes_consumed, bytes_consumed_next;
  logic               halted, halted_next;

  // result queue
  result_t    queue [QDEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       cfg_write;
  logic       in_fire, out_fire;
  logic [1:0] push_n;
  result_t    res0, res1;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base      <= '0;
      preferred_base <= '0;
      table_bytes    <= '0;
      riscv_types    <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_LOAD_BASE:      load_base      <= pwdata;
        REG_PREFERRED_BASE: preferred_base <= pwdata;
        REG_TABLE_BYTES:    table_bytes    <= pwdata[31:0];
        REG_RISCV_TYPES:    riscv_types    <= pwdata[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_LOAD_BASE:      prdata = load_base;
      REG_PREFERRED_BASE: prdata = preferred_base;
      REG_TABLE_BYTES:    prdata = {32'd0, table_bytes};
      REG_RISCV_TYPES:    prdata = {63'd0, riscv_types};
      default:            prdata = '0;
    endcase
  end

  assign s_tready = (count <= 3'(QDEPTH - 2));
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign out_fire = m_tvalid && m_tready;

  // Decode of one halfword against the current walk state.
  // res0/res1 are the results in order, push_n how many of them are real.
  always_comb begin
    logic [DATA_W-1:0]  delta;
    logic [31:0]        d32;
    phase_t             cur_phase;
    logic [15:0]        cur_low;
    logic [ADDR_W-1:0]  cur_base;
    logic [ENTRY_W-1:0] cur_entries;
    logic [31:0]        cur_bytes;
    logic               cur_halted;
    logic [31:0]        bytes_inc;
    logic [31:0]        size;
    logic [31:0]        size_less8;
    logic [ENTRY_W-1:0] entries_dec;
    logic [3:0]         rtype;
    logic [ADDR_W-1:0]  entry_off;
    logic               entry_v, tail_v, stop;
    result_t            entry_r, tail_r;

    delta = load_base - preferred_base;
    d32   = delta[31:0];

    // a first-marked halfword sees the walk from its start
    if (s_tuser[0]) begin
      cur_phase   = PH_BASE_LO;
      cur_low     = '0;
      cur_base    = '0;
      cur_entries = '0;
      cur_bytes   = '0;
      cur_halted  = 1'b0;
    end else begin
      cur_phase   = phase;
      cur_low     = low_half;
      cur_base    = page_base;
      cur_entries = entries_left;
      cur_bytes   = bytes_consumed;
      cur_halted  = halted;
    end

    phase_next          = cur_phase;
    low_half_next       = cur_low;
    page_base_next      = cur_base;
    entries_left_next   = cur_entries;
    bytes_consumed_next = cur_bytes;
    halted_next         = cur_halted;

    bytes_inc   = (cur_bytes > 32'hffff_fffd) ? 32'hffff_ffff : cur_bytes + 32'd2;
    size        = {s_tdata, cur_low};
    size_less8  = size - MIN_BLOCK_BYTES;
    entries_dec = cur_entries - 1'b1;
    rtype       = s_tdata[15:12];
    entry_off   = cur_base + {20'd0, s_tdata[11:0]};

    entry_v = 1'b0;
    tail_v  = 1'b0;
    stop    = 1'b0;
    entry_r = '{last: 1'b0, addend: '0, patch_op: OP_ADD16_HIGH,
                patch_offset: entry_off, status: ST_PATCH};
    tail_r  = '{last: 1'b1, addend: '0, patch_op: OP_ADD16_HIGH,
                patch_offset: '0, status: ST_DONE};

    if (cur_halted) begin
      // walk halted: nothing until the next restart
    end else if (delta == '0 || (cur_phase == PH_BASE_LO && cur_bytes >= table_bytes)) begin
      tail_v      = 1'b1;
      halted_next = 1'b1;
    end else begin
      bytes_consumed_next = bytes_inc;
      unique case (cur_phase)
        PH_BASE_LO: begin
          low_half_next = s_tdata;
          phase_next    = PH_BASE_HI;
        end
        PH_BASE_HI: begin
          page_base_next = size;
          phase_next     = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          low_half_next = s_tdata;
          phase_next    = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          if (size == '0) begin
            tail_v      = 1'b1;
            halted_next = 1'b1;
          end else if (size < MIN_BLOCK_BYTES) begin
            tail_v        = 1'b1;
            tail_r.status = ST_MALFORMED;
            halted_next   = 1'b1;
          end else begin
            entries_left_next = size_less8[ENTRY_W:1];
            if (size_less8[ENTRY_W:1] == '0) begin
              // empty block: straight to the next header
              phase_next = PH_BASE_LO;
              if (bytes_inc >= table_bytes) begin
                tail_v      = 1'b1;
                halted_next = 1'b1;
              end
            end else begin
              phase_next = PH_ENTRY;
            end
          end
        end
        PH_ENTRY: begin
          case (rtype)
            RT_ABSOLUTE: ;
            RT_HIGH: begin
              entry_v          = 1'b1;
              entry_r.patch_op = OP_ADD16_HIGH;
              entry_r.addend   = {48'd0, d32[31:16]};
            end
            RT_LOW: begin
              entry_v          = 1'b1;
              entry_r.patch_op = OP_ADD16_LOW;
              entry_r.addend   = {48'd0, delta[15:0]};
            end
            RT_HIGHLOW: begin
              entry_v          = 1'b1;
              entry_r.patch_op = OP_ADD32;
              entry_r.addend   = {32'd0, d32};
            end
            RT_DIR64: begin
              entry_v          = 1'b1;
              entry_r.patch_op = OP_ADD64;
              entry_r.addend   = delta;
            end
            RT_RISCV_HI20: begin
              entry_v = 1'b1;
              if (riscv_types) begin
                entry_r.patch_op = OP_HI20_MERGE;
                entry_r.addend   = {32'd0, d32};
              end else begin
                entry_r.status = ST_UNKNOWN;
                stop           = 1'b1;
              end
            end
            RT_RISCV_LOW12I, RT_RISCV_LOW12S: begin
              if (!riscv_types) begin
                entry_v        = 1'b1;
                entry_r.status = ST_UNKNOWN;
                stop           = 1'b1;
              end else if ((d32[11:0] & PAGE_MASK) != '0) begin
                // low12 fixups need a page-aligned delta
                entry_v        = 1'b1;
                entry_r.status = ST_MISALIGNED;
                stop           = 1'b1;
              end
            end
            default: begin
              entry_v        = 1'b1;
              entry_r.status = ST_UNKNOWN;
              stop           = 1'b1;
            end
          endcase

          if (stop) begin
            halted_next = 1'b1;
          end else begin
            entries_left_next = entries_dec;
            if (entries_dec == '0) begin
              phase_next = PH_BASE_LO;
              if (bytes_inc >= table_bytes) begin
                tail_v      = 1'b1;
                halted_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    entry_r.last = !tail_v;
    res0   = entry_v ? entry_r : tail_r;
    res1   = tail_r;
    push_n = {1'b0, entry_v} + {1'b0, tail_v};
  end

  // walk state and result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BASE_LO;
      low_half       <= '0;
      page_base      <= '0;
      entries_left   <= '0;
      bytes_consumed <= '0;
      halted         <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (in_fire) begin
        phase          <= phase_next;
        low_half       <= low_half_next;
        page_base      <= page_base_next;
        entries_left   <= entries_left_next;
        bytes_consumed <= bytes_consumed_next;
        halted         <= halted_next;
      end
      wr_ptr <= wr_ptr + (in_fire ? push_n : 2'd0);
      rd_ptr <= rd_ptr + {1'b0, out_fire};
      count  <= count + {1'b0, (in_fire ? push_n : 2'd0)} - {2'd0, out_fire};
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  assign m_tdata = {2'd0, queue[rd_ptr].addend, queue[rd_ptr].patch_op,
                    queue[rd_ptr].patch_offset, queue[rd_ptr].status};
  assign m_tlast = queue[rd_ptr].last;

`include "pe_base_relocation_walker_assert.svh"

  `PBRW_ASSERT_NOW(a_queue_bound, 1'b1, count <= 3'(QDEPTH), "result queue overfilled")
  `PBRW_ASSERT_NEXT(a_count_track, 1'b1,
    count == $past(count) + {1'b0, ($past(in_fire) ? $past(push_n) : 2'd0)}
             - {2'd0, $past(out_fire)}, "queue count lost track of pushes and pops")
  `PBRW_ASSERT_NOW(a_halted_silent, in_fire && halted && !s_tuser[0], push_n == 2'd0,
    "halted walk produced a result")
  `PBRW_ASSERT_NEXT(a_stop_halts, in_fire && push_n != 2'd0 && (push_n == 2'd2 ?
    res1.status != ST_PATCH : res0.status != ST_PATCH), halted,
    "done or error result did not halt the walk")

endmodule

`default_nettype wire

/* verif/tb_pe_base_relocation_walker.sv */
`timescale 1ns / 1ps
// Self-checking bench for pe_base_relocation_walker: streams relocation tables in,
// predicts every patch, done and error result, and checks them in order.
// Depends on pbrw_pkg and the walker RTL.

module tb_pe_base_relocation_walker
  import pbrw_pkg::*;
();

  // Where the walk stands inside the current relocation block.
  typedef enum logic [2:0] {
    HDR_PAGE_LO,
    HDR_PAGE_HI,
    HDR_SIZE_LO,
    HDR_SIZE_HI,
    HDR_ENTRIES
  } walk_phase_t;

  // Predicts the results of each accepted halfword and checks the result stream.
  class patch_scoreboard;
    // register copies
    logic [63:0] load_base;
    logic [63:0] preferred_base;
    logic [31:0] table_bytes;
    logic        riscv_on;
    // walk state
    walk_phase_t phase;
    logic [15:0] low_half;
    logic [31:0] page_base;
    logic [30:0] entries_left;
    logic [31:0] bytes_read;
    logic        halted;

    result_t expected_patches[$];
    result_t step_out[2];
    int      step_n;

    int mismatches;
    int halves_taken;
    int results_seen;
    int patches_seen;

    function new();
      load_base = '0;
      preferred_base = '0;
      table_bytes = '0;
      riscv_on = 1'b0;
      mismatches = 0;
      halves_taken = 0;
      results_seen = 0;
      patches_seen = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      phase = HDR_PAGE_LO;
      low_half = '0;
      page_base = '0;
      entries_left = '0;
      bytes_read = '0;
      halted = 1'b0;
    endfunction

    function void write_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_LOAD_BASE:      load_base = value;
        REG_PREFERRED_BASE: preferred_base = value;
        REG_TABLE_BYTES:    table_bytes = value[31:0];
        REG_RISCV_TYPES:    riscv_on = value[0];
        default: ;
      endcase
    endfunction

    function void add_result(logic [2:0] st, logic [31:0] off, logic [2:0] op,
                             logic [63:0] add);
      result_t r;
      r.status = st;
      r.patch_offset = off;
      r.patch_op = op;
      r.addend = add;
      r.last = 1'b0;
      step_out[step_n] = r;
      step_n++;
    endfunction

    // Called once per accepted halfword; queues the 0..2 results it causes.
    function void predict_patches(logic [15:0] half, logic first);
      logic [63:0] delta;
      logic [31:0] size;
      logic [31:0] off;
      logic [3:0]  kind;
      logic        bad_kind;
      result_t     r;
      step_n = 0;
      bad_kind = 1'b0;
      halves_taken++;
      delta = load_base - preferred_base;
      if (first) restart_walk();
      if (halted) return;

      // Done and malformed results carry zero offset, op and addend; others carry the entry offset.
      if (delta == 0 || (phase == HDR_PAGE_LO && bytes_read >= table_bytes)) begin
        add_result(ST_DONE, '0, OP_ADD16_HIGH, '0);
        halted = 1'b1;
      end else begin
        bytes_read = (bytes_read > 32'hffff_fffd) ? 32'hffff_ffff : bytes_read + 32'd2;
        case (phase)
          HDR_PAGE_LO: begin
            low_half = half;
            phase = HDR_PAGE_HI;
          end
          HDR_PAGE_HI: begin
            page_base = {half, low_half};
            phase = HDR_SIZE_LO;
          end
          HDR_SIZE_LO: begin
            low_half = half;
            phase = HDR_SIZE_HI;
          end
          HDR_SIZE_HI: begin
            size = {half, low_half};
            if (size == 0) begin
              add_result(ST_DONE, '0, OP_ADD16_HIGH, '0);
              halted = 1'b1;
            end else if (size < MIN_BLOCK_BYTES) begin
              add_result(ST_MALFORMED, '0, OP_ADD16_HIGH, '0);
              halted = 1'b1;
            end else begin
              // odd sizes drop their last byte here
              entries_left = 31'((size - MIN_BLOCK_BYTES) >> 1);
              phase = (entries_left == 0) ? HDR_PAGE_LO : HDR_ENTRIES;
              if (entries_left == 0 && bytes_read >= table_bytes) begin
                add_result(ST_DONE, '0, OP_ADD16_HIGH, '0);
                halted = 1'b1;
              end
            end
          end
          default: begin
            kind = half[15:12];
            off = page_base + {20'h0, half[11:0]};
            case (kind)
              RT_ABSOLUTE: ;
              RT_HIGH:     add_result(ST_PATCH, off, OP_ADD16_HIGH, {48'h0, delta[31:16]});
              RT_LOW:      add_result(ST_PATCH, off, OP_ADD16_LOW, {48'h0, delta[15:0]});
              RT_HIGHLOW:  add_result(ST_PATCH, off, OP_ADD32, {32'h0, delta[31:0]});
              RT_DIR64:    add_result(ST_PATCH, off, OP_ADD64, delta);
              RT_RISCV_HI20:
                if (riscv_on) add_result(ST_PATCH, off, OP_HI20_MERGE, {32'h0, delta[31:0]});
                else bad_kind = 1'b1;
              RT_RISCV_LOW12I, RT_RISCV_LOW12S:
                if (!riscv_on) begin
                  bad_kind = 1'b1;
                end else if (delta[11:0] != 0) begin
                  add_result(ST_MISALIGNED, off, OP_ADD16_HIGH, '0);
                  halted = 1'b1;
                end
              default: bad_kind = 1'b1;
            endcase
            if (bad_kind) begin
              add_result(ST_UNKNOWN, off, OP_ADD16_HIGH, '0);
              halted = 1'b1;
            end
            if (!halted) begin
              entries_left = entries_left - 31'd1;
              if (entries_left == 0) begin
                phase = HDR_PAGE_LO;
                // end of table is only looked at on block boundaries
                if (bytes_read >= table_bytes) begin
                  add_result(ST_DONE, '0, OP_ADD16_HIGH, '0);
                  halted = 1'b1;
                end
              end
            end
          end
        endcase
      end

      for (int k = 0; k < step_n; k++) begin
        r = step_out[k];
        r.last = (k == step_n - 1);
        expected_patches.push_back(r);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_patch_result(logic [103:0] data, logic tlast);
      result_t want;
      if (expected_patches.size() == 0) begin
        report_mismatch($sformatf("result with status %0d and nothing expected", data[2:0]));
        return;
      end
      want = expected_patches.pop_front();
      results_seen++;
      if (want.status == ST_PATCH) patches_seen++;
      if (data[2:0] !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", data[2:0], want.status));
      if (data[34:3] !== want.patch_offset)
        report_mismatch($sformatf("patch_offset %h, expected %h", data[34:3],
                                  want.patch_offset));
      if (data[37:35] !== want.patch_op)
        report_mismatch($sformatf("patch_op %0d, expected %0d", data[37:35], want.patch_op));
      if (data[101:38] !== want.addend)
        report_mismatch($sformatf("addend %h, expected %h", data[101:38], want.addend));
      if (tlast !== want.last)
        report_mismatch($sformatf("tlast %b, expected %b", tlast, want.last));
    endtask
  endclass

  // This limit only catches a hang.
  localparam int CYCLE_LIMIT = 400_000;

  logic         clk;
  logic         rst;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_tvalid;
  logic         s_tready;
  logic [15:0]  s_tdata;   // [15:0] table_half
  logic [0:0]   s_tuser;   // [0] first
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // [2:0] status, [34:3] patch_offset, [37:35] patch_op,
                           // [101:38] addend, zero pad
  logic         m_tlast;

  patch_scoreboard sb;
  int src_idle;            // percent of cycles the table source holds back
  int rx_idle;             // percent of cycles the result sink stalls
  int cycle_count;
  int settings_used;

  pe_base_relocation_walker dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result sink: ready changes on the falling edge only.
  always @(negedge clk) begin
    m_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
  end

  // Result monitor, sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_patch_result(m_tdata, m_tlast);
  end

  // One APB write: setup cycle, access cycle, then back to idle, with a look at
  // the read data of the same register. Starts and ends on a falling edge.
  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] want;
    case (idx)
      REG_TABLE_BYTES: want = {32'h0, value[31:0]};
      REG_RISCV_TYPES: want = {63'h0, value[0]};
      default:         want = value;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    if (prdata !== want)
      sb.report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [63:0] lb, input logic [63:0] pb,
                               input logic [31:0] tb, input logic rv);
    write_register(REG_LOAD_BASE, lb);
    write_register(REG_PREFERRED_BASE, pb);
    write_register(REG_TABLE_BYTES, {32'h0, tb});
    write_register(REG_RISCV_TYPES, {63'h0, rv});
    settings_used++;
  endtask

  // Offer one halfword, with random hold-off, and wait for it to be taken.
  // tvalid stays high on return so back-to-back items need no re-raise.
  task automatic send_half(input logic [15:0] half, input logic first);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= half;
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    sb.predict_patches(half, first);
    @(negedge clk);
  endtask

  // Hold the source until every expected result is out, then let items that made no result settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.expected_patches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random tables: mostly well-formed block sequences with random entries,
  // some cut short, some with noise after the walk has halted.
  task automatic run_phase(input int budget);
    logic [15:0] q[$];
    logic [31:0] page;
    logic [31:0] size;
    logic [3:0]  kind;
    logic [11:0] off12;
    int left;
    int nblk;
    int nent;
    int cut;
    int r;
    bit paused;
    left = budget;
    paused = 0;
    while (left > 0) begin
      q.delete();
      nblk = $urandom_range(4, 1);
      for (int b = 0; b < nblk; b++) begin
        page = $urandom;
        page[11:0] = '0;
        r = $urandom_range(9);
        if (r == 0) page = '0;
        else if (r == 1) page = 32'hffff_ffff;   // offset add wraps
        r = $urandom_range(99);
        if (r < 2) size = $urandom_range(7, 1);  // malformed
        else if (r < 5) size = '0;               // end of table
        else if (r < 8) size = $urandom | 32'h0001_0000;  // huge, never completed
        else size = 8 + 2 * $urandom_range(12, 0) + ($urandom_range(7, 0) == 0);
        q.push_back(page[15:0]);
        q.push_back(page[31:16]);
        q.push_back(size[15:0]);
        q.push_back(size[31:16]);
        if (size < MIN_BLOCK_BYTES) nent = 0;
        else if (((size - MIN_BLOCK_BYTES) >> 1) > 16) nent = 16;
        else nent = int'((size - MIN_BLOCK_BYTES) >> 1);
        for (int e = 0; e < nent; e++) begin
          r = $urandom_range(999);
          if (r < 120) kind = RT_ABSOLUTE;
          else if (r < 300) kind = RT_HIGH;
          else if (r < 480) kind = RT_LOW;
          else if (r < 660) kind = RT_HIGHLOW;
          else if (r < 835) kind = RT_DIR64;
          else if (r < 895) kind = RT_RISCV_HI20;
          else if (r < 940) kind = RT_RISCV_LOW12I;
          else if (r < 985) kind = RT_RISCV_LOW12S;
          else begin
            do kind = 4'($urandom);
            while (kind inside {RT_ABSOLUTE, RT_HIGH, RT_LOW, RT_HIGHLOW, RT_DIR64,
                                RT_RISCV_HI20, RT_RISCV_LOW12I, RT_RISCV_LOW12S});
          end
          off12 = ($urandom_range(15) == 0) ? PAGE_MASK : 12'($urandom);
          q.push_back({kind, off12});
        end
      end
      // zero-size terminator block
      if ($urandom_range(9) < 6) begin
        q.push_back(16'($urandom));
        q.push_back(16'($urandom));
        q.push_back(16'h0000);
        q.push_back(16'h0000);
      end
      cut = ($urandom_range(9) == 0) ? $urandom_range(q.size(), 1) : q.size();

      for (int i = 0; i < cut && left > 0; i++) begin
        send_half(q[i], i == 0);
        left--;
        if (sb.halted) break;
      end
      // halted walk swallows these; they don't count toward the budget
      if (sb.halted && $urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) send_half(16'($urandom), 1'b0);

      // one full drain mid-phase
      if (!paused && left < budget / 2) begin
        drain_results();
        paused = 1;
      end
    end
  endtask

  initial begin
    logic [16:0] script[$];   // {first, table_half}
    logic [63:0] lb;
    logic [63:0] pb;
    logic [63:0] step;
    logic [31:0] tb;
    logic        rv;
    int          budget;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    src_idle = 19;
    rx_idle = 87;
    cycle_count = 0;
    settings_used = 0;
    sb = new();

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed tables. Delta ffff_ffff_ffff_f000 is page aligned, RISC-V on,
    // table ends at 28 bytes.
    apply_setting(64'hffff_ffff_ffff_f000, 64'h0, 32'd28, 1'b1);
    script = '{
      // page ffff_f000, 22 bytes: absolute, every patch kind, aligned LOW12S
      17'h1_f000, 17'h0_ffff, 17'h0_0016, 17'h0_0000,
      17'h0_0000, 17'h0_1fff, 17'h0_2000, 17'h0_3123,
      17'h0_a456, 17'h0_5789, 17'h0_8fff,
      // odd size 9, no entries, crosses table_bytes on its header
      17'h0_ffff, 17'h0_ffff, 17'h0_0009, 17'h0_0000,
      // size 3 is malformed; the next halfword is dropped by the halted walk
      17'h1_0000, 17'h0_0000, 17'h0_0003, 17'h0_0000, 17'h0_ffff,
      // one entry of an unknown kind
      17'h1_1000, 17'h0_0000, 17'h0_000a, 17'h0_0000, 17'h0_f000,
      // zero block size ends the table
      17'h1_0000, 17'h0_8000, 17'h0_0000, 17'h0_0000
    };
    foreach (script[i]) send_half(script[i][15:0], script[i][16]);
    drain_results();
    // zero delta: any halfword just reports done
    write_register(REG_LOAD_BASE, 64'h0);
    send_half(16'h1234, 1'b1);
    drain_results();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      lb = {$urandom, $urandom};
      step = {$urandom, $urandom};
      step[11:0] = '0;
      if (step == 0) step = 64'h1000;
      pb = lb - step;
      tb = $urandom_range(256, 16);
      rv = 1'b1;
      budget = 244;
      case (ph)
        0: begin
          lb = 64'h0000_0001_4000_0000;
          pb = 64'h0000_0001_0000_0000;
          tb = 32'd96;
        end
        1: begin
          // all-ones delta, misaligned; table never ends on size
          lb = 64'h0;
          pb = 64'h1;
          tb = 32'hffff_ffff;
        end
        2: rv = 1'b0;
        3: begin
          // empty table: every walk ends on its first halfword
          lb = 64'hffff_ffff_ffff_ffff;
          pb = 64'h0;
          tb = 32'h0;
          budget = 40;
        end
        4: tb = $urandom_range(400, 8);
        5: pb = {$urandom, $urandom};
        6: tb = $urandom_range(64, 0);
        default: begin
          lb = 64'h0;
          pb = 64'h8000_0000_0000_0000;
          tb = 32'hffff_ffff;
          rv = 1'b0;
        end
      endcase
      // Idle mix: slow sink first, then slow source, then full rate.
      if (ph < 3) begin
        src_idle = 19;
        rx_idle = 87;
      end else if (ph < 6) begin
        src_idle = 87;
        rx_idle = 19;
      end else begin
        src_idle = 0;
        rx_idle = 0;
      end
      apply_setting(lb, pb, tb, rv);
      run_phase(budget);
      drain_results();
    end

    // Let the pipe settle, then look for stragglers.
    s_tvalid <= 1'b0;
    repeat (8) @(posedge clk);
    if (sb.expected_patches.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came",
                                   sb.expected_patches.size()));

    $display("walked %0d table halfwords under %0d register settings",
             sb.halves_taken, settings_used);
    $display("checked %0d results, %0d of them patch commands",
             sb.results_seen, sb.patches_seen);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
